// ===== hw/rtl/klmp_pkg.sv =====
// Package for the key-metadata TLV parser: word types, result and error codes,
// parse phases, queue sizing and the Base64 character decode function.
// Used by every module of the parser and by its checker.
package klmp_pkg;

  // Record types and format limits. The highest format version is also the
  // one under which IV and key records are Base64 text.
  localparam logic [7:0] TYPE_IV            = 8'd1;
  localparam logic [7:0] TYPE_KEYVERSION    = 8'd2;
  localparam logic [7:0] TYPE_EEK           = 8'd3;
  localparam logic [7:0] TYPE_MKNAME        = 8'd4;
  localparam logic [7:0] FORMAT_VERSION_MAX = 8'd2;
  localparam logic [1:0] LENGTH_LAST_IDX    = 2'd3;  // fourth length byte

  // Result kinds.
  localparam logic [2:0] KIND_IV     = 3'd0;
  localparam logic [2:0] KIND_KEY    = 3'd1;
  localparam logic [2:0] KIND_NAME   = 3'd2;
  localparam logic [2:0] KIND_KEYVER = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_VERSION = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE    = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
  localparam logic [2:0] ERR_BAD_BASE64  = 3'd4;
  localparam logic [2:0] ERR_SHORT_KEYVER = 3'd5;

  // Decoded Base64 character markers.
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd127;

  // One input byte yields at most three data results and one terminator.
  localparam int MAX_RESULTS = 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [31:0] item_value;
    logic        field_end;
    logic [2:0]  error_code;
    logic        run_last;
  } out_word_t;

  // All results caused by one accepted byte.
  typedef struct packed {
    logic [2:0]                        count;
    out_word_t [MAX_RESULTS-1:0]       word;
  } bundle_t;

  // Head-of-queue view handed to the output stage.
  typedef struct packed {
    logic    empty;
    bundle_t head;
  } queue_view_t;

  // Standard alphabet: 0..63, SEXTET_PAD for '=', SEXTET_BAD otherwise.
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin         // 'A'..'Z'
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin  // 'a'..'z'
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin  // '0'..'9'
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin                // '+'
      v = 7'd62;
    end else if (c == 8'h2F) begin                // '/'
      v = 7'd63;
    end else if (c == 8'h3D) begin                // '='
      v = SEXTET_PAD;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/klmp_parse.sv =====
// Parse stage: holds the TLV parse state and turns one accepted byte into a
// bundle of up to four results. Depends on klmp_pkg.
module klmp_parse import klmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t word,
  output logic     push,
  output bundle_t  bundle
);

  phase_t      phase, phase_next;
  logic [1:0]  format_version, format_version_next;
  logic [2:0]  record_type, record_type_next;
  logic [1:0]  length_bytes_seen, length_bytes_seen_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [23:0] b64_acc, b64_acc_next;
  logic [1:0]  b64_count, b64_count_next;
  logic        pad_seen, pad_seen_next;
  logic [31:0] kv_acc, kv_acc_next;

  logic [7:0]  b;
  logic [31:0] rem;
  logic        rem_zero;
  logic [31:0] length_full;
  logic [6:0]  sx;
  logic        is_pad, is_bad;
  logic [23:0] acc_shift;
  logic [1:0]  nb;
  logic [2:0]  err, err_final;
  logic [1:0]  data_n;
  logic [2:0]  data_kind;
  logic [31:0] data_val [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] data_fend;
  logic        term;
  out_word_t   term_word;
  logic [2:0]  count;
  out_word_t   w;

  assign b           = word.in_byte;
  assign rem         = bytes_remaining - 32'd1;
  assign rem_zero    = (bytes_remaining == 32'd1);
  assign length_full = {bytes_remaining[23:0], b};
  assign sx          = sextet(b);
  assign is_pad      = (sx == SEXTET_PAD);
  assign is_bad      = (sx == SEXTET_BAD);
  assign acc_shift   = {b64_acc[17:0], is_pad ? 6'd0 : sx[5:0]};
  assign nb          = pad_seen ? 2'd1 : (is_pad ? 2'd2 : 2'd3);

  always_comb begin
    phase_next             = phase;
    format_version_next    = format_version;
    record_type_next       = record_type;
    length_bytes_seen_next = length_bytes_seen;
    bytes_remaining_next   = bytes_remaining;
    b64_acc_next           = b64_acc;
    b64_count_next         = b64_count;
    pad_seen_next          = pad_seen;
    kv_acc_next            = kv_acc;
    err                    = ERR_NONE;
    data_n                 = 2'd0;
    data_kind              = KIND_IV;
    data_fend              = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      data_val[k] = '0;
    end

    unique case (phase)
      PH_VERSION: begin
        if (b < 8'd1 || b > FORMAT_VERSION_MAX) begin
          err = ERR_BAD_VERSION;
        end else begin
          format_version_next = b[1:0];
          phase_next          = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b < TYPE_IV || b > TYPE_MKNAME) begin
          err = ERR_BAD_TYPE;
        end else begin
          record_type_next       = b[2:0];
          length_bytes_seen_next = 2'd0;
          bytes_remaining_next   = '0;
          phase_next             = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_remaining_next = length_full;
        if (length_bytes_seen != LENGTH_LAST_IDX) begin
          length_bytes_seen_next = length_bytes_seen + 2'd1;
        end else begin
          length_bytes_seen_next = 2'd0;
          b64_acc_next           = '0;
          b64_count_next         = 2'd0;
          pad_seen_next          = 1'b0;
          kv_acc_next            = '0;
          if (record_type == TYPE_KEYVERSION[2:0] && length_full < 32'd4) begin
            err = ERR_SHORT_KEYVER;
          end else if ((record_type == TYPE_IV[2:0] || record_type == TYPE_EEK[2:0]) &&
                       format_version == FORMAT_VERSION_MAX[1:0] &&
                       length_full[1:0] != 2'd0) begin
            err = ERR_BAD_BASE64;
          end else begin
            phase_next = (length_full != 32'd0) ? PH_DATA : PH_TYPE;
          end
        end
      end
      PH_DATA: begin
        bytes_remaining_next = rem;
        if (record_type == TYPE_KEYVERSION[2:0]) begin
          kv_acc_next = {kv_acc[23:0], b};
          if (length_bytes_seen == LENGTH_LAST_IDX) begin
            length_bytes_seen_next = 2'd0;
            data_n                 = 2'd1;
            data_kind              = KIND_KEYVER;
            data_val[0]            = {kv_acc[23:0], b};
            data_fend[0]           = 1'b1;
            phase_next             = rem_zero ? PH_TYPE : PH_SKIP;
          end else begin
            length_bytes_seen_next = length_bytes_seen + 2'd1;
          end
        end else if (record_type == TYPE_MKNAME[2:0] || format_version == 2'd1) begin
          data_n       = 2'd1;
          data_kind    = (record_type == TYPE_IV[2:0])  ? KIND_IV :
                         (record_type == TYPE_EEK[2:0]) ? KIND_KEY : KIND_NAME;
          data_val[0]  = {24'd0, b};
          data_fend[0] = rem_zero;
          if (rem_zero) begin
            phase_next = PH_TYPE;
          end
        end else begin
          // Base64 character; a padded group must close its record.
          data_kind = (record_type == TYPE_IV[2:0]) ? KIND_IV : KIND_KEY;
          if (is_bad) begin
            err = ERR_BAD_BASE64;
          end else if (is_pad && b64_count < 2'd2) begin
            err = ERR_BAD_BASE64;
          end else if (!is_pad && pad_seen) begin
            err = ERR_BAD_BASE64;
          end else if (b64_count == 2'd3 && nb != 2'd3 && !rem_zero) begin
            err = ERR_BAD_BASE64;
          end else begin
            if (b64_count == 2'd3) begin
              data_n       = nb;
              data_val[0]  = {24'd0, acc_shift[23:16]};
              data_val[1]  = {24'd0, acc_shift[15:8]};
              data_val[2]  = {24'd0, acc_shift[7:0]};
              data_fend[0] = rem_zero && nb == 2'd1;
              data_fend[1] = rem_zero && nb == 2'd2;
              data_fend[2] = rem_zero && nb == 2'd3;
              b64_count_next = 2'd0;
              b64_acc_next   = '0;
              pad_seen_next  = 1'b0;
            end else begin
              b64_acc_next   = acc_shift;
              b64_count_next = b64_count + 2'd1;
              if (is_pad) begin
                pad_seen_next = 1'b1;
              end
            end
            if (rem_zero) begin
              phase_next = PH_TYPE;
            end
          end
        end
      end
      PH_SKIP: begin
        bytes_remaining_next = rem;
        if (rem_zero) begin
          phase_next = PH_TYPE;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    // Terminating result: error, or done at the end of a clean blob.
    term      = 1'b0;
    term_word = '0;
    err_final = err;
    if (phase != PH_DRAIN) begin
      if (err == ERR_NONE && word.in_last && phase_next != PH_TYPE) begin
        err_final = ERR_TRUNCATED;
      end
      if (err_final != ERR_NONE) begin
        term                 = 1'b1;
        term_word.item_kind  = KIND_ERROR;
        term_word.error_code = err_final;
        phase_next           = PH_DRAIN;
      end else if (word.in_last) begin
        term                = 1'b1;
        term_word.item_kind = KIND_DONE;
      end
    end

    // The last byte of a blob returns the parser to its reset state.
    if (word.in_last) begin
      phase_next             = PH_VERSION;
      format_version_next    = '0;
      record_type_next       = '0;
      length_bytes_seen_next = '0;
      bytes_remaining_next   = '0;
      b64_acc_next           = '0;
      b64_count_next         = '0;
      pad_seen_next          = 1'b0;
      kv_acc_next            = '0;
    end

    count = {1'b0, data_n} + {2'b0, term};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      w = '0;
      if (3'(i) < {1'b0, data_n}) begin
        w.item_kind  = data_kind;
        w.item_value = data_val[i];
        w.field_end  = data_fend[i];
      end else if (term && 3'(i) == {1'b0, data_n}) begin
        w = term_word;
      end
      w.run_last     = (3'(i) + 3'd1 == count);
      bundle.word[i] = w;
    end
    bundle.count = count;
  end

  assign push = accept && (count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_VERSION;
      format_version    <= '0;
      record_type       <= '0;
      length_bytes_seen <= '0;
      bytes_remaining   <= '0;
      b64_acc           <= '0;
      b64_count         <= '0;
      pad_seen          <= 1'b0;
      kv_acc            <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      format_version    <= format_version_next;
      record_type       <= record_type_next;
      length_bytes_seen <= length_bytes_seen_next;
      bytes_remaining   <= bytes_remaining_next;
      b64_acc           <= b64_acc_next;
      b64_count         <= b64_count_next;
      pad_seen          <= pad_seen_next;
      kv_acc            <= kv_acc_next;
    end
  end

endmodule

// ===== hw/rtl/klmp_fifo.sv =====
// Result queue: holds result bundles between the parse stage and the output
// stage, one bundle per entry. Depends on klmp_pkg.
module klmp_fifo import klmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bundle_t     push_data,
  input  logic        pop,
  output logic        full,
  output queue_view_t view
);

  bundle_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     fill;

  assign full       = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign view.empty = (fill == '0);
  assign view.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/klmp_emit.sv =====
// Output stage: walks the results of the bundle at the queue head and hands
// them out one word per handshake. Depends on klmp_pkg.
module klmp_emit import klmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_view_t view,
  input  logic        item_stall,
  output logic        item_valid,
  output out_word_t   item_word,
  output logic        pop
);

  logic [1:0] idx;
  logic       last_of_bundle;

  assign item_valid     = !view.empty;
  assign item_word      = view.head.word[idx];
  assign last_of_bundle = ({1'b0, idx} + 3'd1 == view.head.count);
  assign pop            = item_valid && !item_stall && last_of_bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (item_valid && !item_stall) begin
      idx <= last_of_bundle ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== hw/rtl/key_metadata_tlv_parser_top.sv =====
// Key-metadata TLV parser. Results of an accepted byte are registered in the
// result queue before they are offered. Throughput: one byte per cycle in
// unless byte_stall, one result per cycle out unless item_stall; a four-entry
// result queue sets when byte_stall rises, and a byte's results go out in turn.
// Reset is synchronous on rst: parse state returns to "expect version" and the
// result queue empties.
//
// The blob starts with a version byte (1 or 2), then records of type byte,
// 32-bit big-endian length and data. Under version 2 the IV and encrypted key
// records are Base64 text, and every fourth character releases up to three
// bytes. The key version record yields one 32-bit unsigned word. Any error is
// reported once, after which bytes are dropped until the byte marked in_last.
//
// Structure: the parse stage works out all results of a byte combinationally
// and writes them as one bundle into the queue; the output stage then presents
// the bundle's words in order, flagging the last one with run_last.
module key_metadata_tlv_parser_top import klmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      item_valid,
  input  logic      item_stall,
  output out_word_t item_word
);

  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  bundle_t     bundle;
  queue_view_t view;

  // The stall is a registered queue-full flag, so it never waits on the
  // output side within the same cycle.
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  klmp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (byte_word),
    .push   (push),
    .bundle (bundle)
  );

  klmp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .full      (full),
    .view      (view)
  );

  klmp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .view       (view),
    .item_stall (item_stall),
    .item_valid (item_valid),
    .item_word  (item_word),
    .pop        (pop)
  );

endmodule

// ===== hw/rtl/klmp_checker.sv =====
// Port-level checker for the key-metadata TLV parser, bound to the top level.
// Depends on klmp_pkg.
module klmp_checker import klmp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_stall,
  input logic      item_valid,
  input logic      item_stall,
  input out_word_t item_word
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item_word))
    else $error("result word changed while stalled");

  // Done and error always close the results of their byte.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    item_valid && (item_word.item_kind == KIND_DONE ||
                   item_word.item_kind == KIND_ERROR) |-> item_word.run_last)
    else $error("terminating result without run_last");

  // An error code appears exactly on error results.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> ((item_word.item_kind == KIND_ERROR) ==
                    (item_word.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // Field end marks only data results.
  a_field_end: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_word.field_end |->
      (item_word.item_kind == KIND_IV || item_word.item_kind == KIND_KEY ||
       item_word.item_kind == KIND_NAME || item_word.item_kind == KIND_KEYVER))
    else $error("field end on a non-data result");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !item_valid && !byte_stall)
    else $error("output not empty after reset");

endmodule

bind key_metadata_tlv_parser_top klmp_checker u_klmp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for key_metadata_tlv_parser_top: random and directed metadata blobs,
// a built-in parser predictor and an in-order result scoreboard.
// Depends on klmp_pkg for the word types, record types, result kinds and error codes.
module testbench;
  import klmp_pkg::*;

  localparam int CLOCK_LIMIT = 300000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES = 60;      // long receiver hold-off, fills the result queue

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_word = '0;
  logic      item_valid;
  logic      item_stall = 1'b0;
  out_word_t item_word;

  key_metadata_tlv_parser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word (byte_word),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item_word (item_word)
  );

  always #6 clk = ~clk;

  // Words waiting to be offered, and results that accepted words are expected to produce.
  in_word_t  pending_bytes[$];
  out_word_t expected_items[$];
  out_word_t byte_results[$];

  int  fail_count = 0;
  int  accepted_bytes = 0; // words accepted by the block, dropped ones included
  int  hold_requests = 0;  // bumped by the stimulus process to ask for a long receiver hold
  bit  idle_on = 1'b1;     // random idle bursts on both sides while set
  int  cycle_count = 0;

  // Parser state mirrored by the predictor.
  phase_t      parse_at;
  logic [1:0]  fmt_ver;
  logic [2:0]  rec_type;
  logic [1:0]  len_idx;      // length byte index, reused as key-version byte index
  logic [31:0] remaining;
  logic [23:0] b64_acc;
  logic [1:0]  b64_cnt;
  logic [31:0] kv_acc;
  logic        err_latched;
  logic        pad_seen;     // '=' seen at the third position of the current group

  function automatic void clear_parser();
    parse_at    = PH_VERSION;
    fmt_ver     = '0;
    rec_type    = '0;
    len_idx     = '0;
    remaining   = '0;
    b64_acc     = '0;
    b64_cnt     = '0;
    kv_acc      = '0;
    err_latched = 1'b0;
    pad_seen    = 1'b0;
  endfunction

  function automatic void note_result(logic [2:0] kind, logic [31:0] value, logic fend,
                                      logic [2:0] code);
    out_word_t r;
    r.item_kind  = kind;
    r.item_value = value;
    r.field_end  = fend;
    r.error_code = code;
    r.run_last   = 1'b0;
    byte_results.push_back(r);
  endfunction

  // Base64 character to its 6-bit value; pad and non-alphabet characters get markers.
  function automatic logic [6:0] b64_sextet(logic [7:0] c);
    if (c inside {["A":"Z"]}) return 7'(c - "A");
    if (c inside {["a":"z"]}) return 7'(c - "a" + 26);
    if (c inside {["0":"9"]}) return 7'(c - "0" + 52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    if (c == "=") return SEXTET_PAD;
    return SEXTET_BAD;
  endfunction

  function automatic logic [7:0] b64_char(int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'("+") : 8'("/");
  endfunction

  // Works out every result one accepted word causes and appends them to expected_items.
  task automatic predict_byte(input in_word_t w);
    logic [7:0]  b;
    logic [2:0]  err;
    logic [31:0] rem;
    logic [6:0]  sx;
    logic [1:0]  pos;
    logic        is_pad;
    int          nb;
    logic [2:0]  kind;
    out_word_t   r;
    b = w.in_byte;
    err = ERR_NONE;
    byte_results.delete();
    accepted_bytes++;
    if (err_latched) begin
      // After an error everything is dropped silently until the final word.
      if (w.in_last) clear_parser();
      return;
    end
    case (parse_at)
      PH_VERSION: begin
        if (b == 8'd0 || b > FORMAT_VERSION_MAX) begin
          err = ERR_BAD_VERSION;
        end else begin
          fmt_ver = b[1:0];
          parse_at = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b < TYPE_IV || b > TYPE_MKNAME) begin
          err = ERR_BAD_TYPE;
        end else begin
          rec_type = b[2:0];
          len_idx = '0;
          remaining = '0;
          parse_at = PH_LEN;
        end
      end
      PH_LEN: begin
        remaining = {remaining[23:0], b};
        if (len_idx != LENGTH_LAST_IDX) begin
          len_idx++;
        end else begin
          len_idx = '0;
          b64_acc = '0;
          b64_cnt = '0;
          pad_seen = 1'b0;
          kv_acc = '0;
          if (rec_type == 3'(TYPE_KEYVERSION) && remaining < 32'd4) begin
            err = ERR_SHORT_KEYVER;
          end else if ((rec_type == 3'(TYPE_IV) || rec_type == 3'(TYPE_EEK)) &&
                       fmt_ver == 2'(FORMAT_VERSION_MAX) && remaining[1:0] != 2'd0) begin
            err = ERR_BAD_BASE64;
          end else begin
            parse_at = (remaining != 0) ? PH_DATA : PH_TYPE;
          end
        end
      end
      PH_DATA: begin
        remaining = remaining - 1;
        rem = remaining;
        if (rec_type == 3'(TYPE_KEYVERSION)) begin
          kv_acc = {kv_acc[23:0], b};
          if (len_idx == LENGTH_LAST_IDX) begin
            len_idx = '0;
            note_result(KIND_KEYVER, kv_acc, 1'b1, ERR_NONE);
            parse_at = (rem != 0) ? PH_SKIP : PH_TYPE;
          end else begin
            len_idx++;
          end
        end else if (rec_type == 3'(TYPE_MKNAME) || fmt_ver != 2'(FORMAT_VERSION_MAX)) begin
          kind = (rec_type == 3'(TYPE_IV)) ? KIND_IV :
                 (rec_type == 3'(TYPE_EEK)) ? KIND_KEY : KIND_NAME;
          note_result(kind, {24'd0, b}, rem == 0, ERR_NONE);
          if (rem == 0) parse_at = PH_TYPE;
        end else begin
          sx = b64_sextet(b);
          pos = b64_cnt;
          is_pad = (sx == SEXTET_PAD);
          if (sx == SEXTET_BAD || (is_pad && pos < 2'd2) || (!is_pad && pad_seen)) begin
            err = ERR_BAD_BASE64;
          end else begin
            if (is_pad) begin
              if (pos == 2'd2) pad_seen = 1'b1;
              sx = '0;
            end
            b64_acc = {b64_acc[17:0], sx[5:0]};
            if (pos == 2'd3) begin
              nb = pad_seen ? 1 : (is_pad ? 2 : 3);
              // A padded group must close its record.
              if (nb < 3 && rem != 0) begin
                err = ERR_BAD_BASE64;
              end else begin
                kind = (rec_type == 3'(TYPE_IV)) ? KIND_IV : KIND_KEY;
                for (int k = 0; k < nb; k++) begin
                  note_result(kind, {24'd0, b64_acc[23-8*k -: 8]},
                              rem == 0 && k == nb - 1, ERR_NONE);
                end
                b64_cnt = '0;
                b64_acc = '0;
                pad_seen = 1'b0;
              end
            end else begin
              b64_cnt = pos + 2'd1;
            end
            if (err == ERR_NONE && rem == 0) parse_at = PH_TYPE;
          end
        end
      end
      PH_SKIP: begin
        remaining = remaining - 1;
        if (remaining == 0) parse_at = PH_TYPE;
      end
      default: ;
    endcase
    if (err == ERR_NONE && w.in_last && parse_at != PH_TYPE) err = ERR_TRUNCATED;
    if (err != ERR_NONE) begin
      note_result(KIND_ERROR, '0, 1'b0, err);
      err_latched = 1'b1;
      parse_at = PH_DRAIN;
    end else if (w.in_last) begin
      note_result(KIND_DONE, '0, 1'b0, ERR_NONE);
    end
    if (w.in_last) clear_parser();
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.run_last = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) expected_items.push_back(byte_results[i]);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_items.size() == 0) begin
      $error("result with nothing expected: kind %0d value %0h code %0d",
             got.item_kind, got.item_value, got.error_code);
      fail_count++;
      return;
    end
    want = expected_items.pop_front();
    if (got.item_kind !== want.item_kind) begin
      $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
      fail_count++;
    end
    if (got.item_value !== want.item_value) begin
      $error("item_value: expected %0h, got %0h", want.item_value, got.item_value);
      fail_count++;
    end
    if (got.field_end !== want.field_end) begin
      $error("field_end: expected %0d, got %0d", want.field_end, got.field_end);
      fail_count++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
      fail_count++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
      fail_count++;
    end
  endtask

  // Queues one blob; the final word carries in_last.
  task automatic queue_run(input logic [7:0] run[$]);
    in_word_t w;
    foreach (run[i]) begin
      w.in_byte = run[i];
      w.in_last = (i == run.size() - 1);
      pending_bytes.push_back(w);
    end
  endtask

  // Builds one random blob. Most are well formed with random records and content; some are
  // damaged (a byte replaced or the blob cut short) and a few are plain noise.
  task automatic queue_blob();
    logic [7:0]  blob[$];
    logic [7:0]  body[$];
    logic [7:0]  ver;
    logic [7:0]  rtype;
    logic [31:0] len;
    int          mode;
    int          ngroups;
    int          pads;
    int          cut;
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      repeat ($urandom_range(1, 6)) blob.push_back(8'($urandom));
    end else begin
      ver = ($urandom_range(0, 3) == 0) ? 8'd1 : FORMAT_VERSION_MAX;
      blob.push_back(ver);
      repeat ($urandom_range(0, 3)) begin
        body.delete();
        rtype = TYPE_IV + 8'($urandom_range(0, 3));
        if (rtype == TYPE_KEYVERSION) begin
          repeat (4 + $urandom_range(0, 3)) body.push_back(8'($urandom));
        end else if (rtype == TYPE_MKNAME || ver != FORMAT_VERSION_MAX) begin
          repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
        end else begin
          // Base64 text; only the closing group may carry one or two pad characters.
          ngroups = $urandom_range(0, 3);
          for (int g = 0; g < ngroups; g++) begin
            pads = (g == ngroups - 1) ? $urandom_range(0, 2) : 0;
            for (int p = 0; p < 4; p++) begin
              body.push_back((p >= 4 - pads) ? 8'("=") : b64_char($urandom_range(0, 63)));
            end
          end
        end
        len = body.size();
        blob.push_back(rtype);
        blob.push_back(len[31:24]);
        blob.push_back(len[23:16]);
        blob.push_back(len[15:8]);
        blob.push_back(len[7:0]);
        blob = {blob, body};
      end
      if (mode < 6) begin
        case ($urandom_range(0, 2))
          0: blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom);
          1: blob[$urandom_range(0, blob.size() - 1)] =
               $urandom_range(0, 1) ? 8'("=") : b64_char($urandom_range(0, 63));
          default: begin
            cut = $urandom_range(1, blob.size());
            while (blob.size() > cut) void'(blob.pop_back());
          end
        endcase
      end
    end
    queue_run(blob);
  endtask

  // Driver: offers queued words, holds a stalled word steady, and inserts random idle
  // bursts while idling is enabled. Every accepted word is predicted at the edge that
  // accepts it.
  int gap_left = 0;
  always @(posedge clk) begin
    logic     offer;
    in_word_t word;
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = byte_valid;
      word = byte_word;
      if (byte_valid && !byte_stall) begin
        predict_byte(byte_word);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 13);
        end else if (pending_bytes.size() > 0) begin
          word = pending_bytes.pop_front();
          offer = 1'b1;
        end
      end
      byte_valid <= offer;
      byte_word <= word;
    end
  end

  // Monitor: checks every accepted result against the oldest expectation and drives the
  // stall. A hold request from the stimulus process starts a long receiver hold, counted
  // down here in hold_left, so the block's queue fills up and it pushes back on its input.
  int stall_left = 0;
  int hold_left = 0;
  int holds_served = 0;
  always @(posedge clk) begin
    logic stall;
    if (rst) begin
      item_stall <= 1'b0;
    end else begin
      if (item_valid && !item_stall) check_result(item_word);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      item_stall <= stall;
    end
  end

  // Watchdog: a run that hangs or loses results ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CLOCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus. All queue and flag updates happen on the falling edge so the clocked
  // driver and monitor see stable values at the rising edge.
  initial begin
    clear_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bad version byte (all ones), the dropped word after it, and recovery on in_last.
    queue_run('{8'hFF, 8'h00, 8'h01});
    // Unknown record type right on the final word.
    queue_run('{FORMAT_VERSION_MAX, 8'h05});
    // Key version shorter than four bytes.
    queue_run('{FORMAT_VERSION_MAX, TYPE_KEYVERSION, 8'h00, 8'h00, 8'h00, 8'h03});
    // A full Base64 group at the end of the blob: three IV bytes plus done, four results.
    queue_run('{FORMAT_VERSION_MAX, TYPE_IV, 8'h00, 8'h00, 8'h00, 8'h04,
                8'("T"), 8'("W"), 8'("F"), 8'("u")});
    // Largest length, then a character outside the Base64 alphabet.
    queue_run('{FORMAT_VERSION_MAX, TYPE_EEK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'("*")});

    // Random blobs with idling on both sides.
    while (accepted_bytes < 90) begin
      if (pending_bytes.size() < 8) queue_blob();
      @(negedge clk);
    end

    // Sender pause: nothing new is offered until every expected result has come out.
    while (pending_bytes.size() != 0 || byte_valid || expected_items.size() != 0) begin
      @(negedge clk);
    end

    // Long receiver hold with the sender offering back to back.
    idle_on = 1'b0;
    while (pending_bytes.size() < 40) queue_blob();
    hold_requests++;
    while (accepted_bytes < 145) begin
      if (pending_bytes.size() < 8) queue_blob();
      @(negedge clk);
    end

    idle_on = 1'b1;
    while (accepted_bytes < 195) begin
      if (pending_bytes.size() < 8) queue_blob();
      @(negedge clk);
    end

    // Final stretch at full rate with no idling.
    idle_on = 1'b0;
    while (accepted_bytes < 240) begin
      if (pending_bytes.size() < 8) queue_blob();
      @(negedge clk);
    end

    while (pending_bytes.size() != 0 || byte_valid || expected_items.size() != 0) begin
      @(negedge clk);
    end
    // Keep the clock running so a stray extra result would still be caught.
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/klmp_pkg.sv
hw/rtl/klmp_parse.sv
hw/rtl/klmp_fifo.sv
hw/rtl/klmp_emit.sv
hw/rtl/key_metadata_tlv_parser_top.sv
hw/rtl/klmp_checker.sv
tb/testbench.sv
